// ===== hdl/reply_frame_checker_top_macros.svh =====
// assertion helpers shared by the checker modules
`ifndef REPLY_FRAME_CHECKER_TOP_MACROS_SVH
`define REPLY_FRAME_CHECKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rfc_pkg.sv =====
package rfc_pkg;

  // longest frame kept, later bytes are dropped
  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);

  localparam logic [7:0] START_BYTE = 8'h06;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;
  localparam logic [7:0] HDR_BYTES  = 8'd6;

  // header byte positions
  localparam logic [CNT_W-1:0] IDX_START  = CNT_W'(0);
  localparam logic [CNT_W-1:0] IDX_CMD    = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDX_LEN    = CNT_W'(2);
  localparam logic [CNT_W-1:0] IDX_ONE    = CNT_W'(3);
  localparam logic [CNT_W-1:0] IDX_NZ     = CNT_W'(4);
  localparam logic [CNT_W-1:0] IDX_HOLD   = CNT_W'(5);
  localparam logic [CNT_W-1:0] IDX_EMIT   = CNT_W'(6);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_REPLY = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_BAD_HDR  = 2'd3
  } status_t;

  // one input item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  // result of one item, has_result low when the item gives none
  typedef struct packed {
    logic       has_result;
    logic       is_status;
    logic [7:0] payload_byte;
    status_t    frame_status;
    logic [7:0] payload_length;
  } result_t;

endpackage

// ===== hdl/rfc_frame_eval.sv =====
`include "reply_frame_checker_top_macros.svh"

module rfc_frame_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rfc_pkg::item_t      item,
  input  logic [7:0]          expected_command,
  output rfc_pkg::result_t    res
);

  logic [rfc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [7:0]                len_r, len_nxt;
  logic                      hdr_ok_r, hdr_ok_nxt;
  logic [7:0]                held_r, held_nxt;
  logic [7:0]                sum_add;
  logic                      len_match;

  assign sum_add   = sum_r + item.rx_byte;
  assign len_match = ({1'b0, len_r} == count_r);

  // per-item frame update and result
  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    hdr_ok_nxt = hdr_ok_r;
    held_nxt   = held_r;
    res        = '0;
    if (item.frame_end) begin
      res.has_result = 1'b1;
      res.is_status  = 1'b1;
      priority if (count_r == '0) begin
        res.frame_status = rfc_pkg::ST_NO_REPLY;
      end else if (sum_r != rfc_pkg::SUM_GOOD) begin
        res.frame_status = rfc_pkg::ST_BAD_SUM;
      end else if (!hdr_ok_r || count_r < rfc_pkg::CNT_W'(rfc_pkg::HDR_BYTES) ||
                   !len_match) begin
        res.frame_status = rfc_pkg::ST_BAD_HDR;
      end else begin
        res.frame_status   = rfc_pkg::ST_OK;
        res.payload_length = count_r[7:0] - rfc_pkg::HDR_BYTES;
      end
      // back to an empty frame
      count_nxt  = '0;
      sum_nxt    = '0;
      len_nxt    = '0;
      hdr_ok_nxt = 1'b1;
      held_nxt   = '0;
    end else if (count_r < rfc_pkg::CNT_W'(rfc_pkg::MAX_FRAME)) begin
      sum_nxt = sum_add;
      unique case (count_r)
        rfc_pkg::IDX_START: begin
          if (item.rx_byte != rfc_pkg::START_BYTE) hdr_ok_nxt = 1'b0;
        end
        rfc_pkg::IDX_CMD: begin
          if (item.rx_byte != expected_command) hdr_ok_nxt = 1'b0;
        end
        rfc_pkg::IDX_LEN: begin
          len_nxt = item.rx_byte;
        end
        rfc_pkg::IDX_ONE: begin
          if (item.rx_byte != 8'd1) hdr_ok_nxt = 1'b0;
        end
        rfc_pkg::IDX_NZ: begin
          if (item.rx_byte == 8'd0) hdr_ok_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      // previous held byte goes out one byte late
      if (count_r >= rfc_pkg::IDX_EMIT) begin
        res.has_result   = 1'b1;
        res.payload_byte = held_r;
      end
      if (count_r >= rfc_pkg::IDX_HOLD) held_nxt = item.rx_byte;
      count_nxt = count_r + 1'b1;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      len_r    <= '0;
      hdr_ok_r <= 1'b1;
      held_r   <= '0;
    end else if (fire) begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      len_r    <= len_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      held_r   <= held_nxt;
    end
  end

  `RFC_ASSERT_NXT(a_end_clears, fire && item.frame_end, count_r == '0, "frame not cleared")
  `RFC_ASSERT_IMP(a_count_cap, 1'b1, count_r <= rfc_pkg::CNT_W'(rfc_pkg::MAX_FRAME), "count overflow")
  `RFC_ASSERT_IMP(a_payload_pos, res.has_result && !res.is_status, count_r >= rfc_pkg::IDX_EMIT && count_r < rfc_pkg::CNT_W'(rfc_pkg::MAX_FRAME), "payload out of place")

endmodule

// ===== hdl/rfc_out_reg.sv =====
module rfc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  rfc_pkg::result_t  res,
  input  logic              out_tready,
  output logic              out_valid,
  output logic              adv_ok,
  output rfc_pkg::result_t  out_res
);

  logic             valid_r;
  rfc_pkg::result_t res_r;

  // the slot is free when empty or being taken this cycle
  assign adv_ok    = !valid_r || out_tready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && res.has_result) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && res.has_result) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/reply_frame_checker_top.sv =====
// reply frame checker
// in_*: one received byte per item, in_tdata = rx_byte; in_tlast high marks
//   the read timeout that closes the frame (in_tdata ignored then).
// out_*: out_tuser low = payload byte, high = end-of-frame status item.
//   Payload bytes come one byte late: the sixth byte goes out when the seventh
//   arrives, and so on, so the checksum byte is never passed out.
// cfg_*: writes the command byte the reply must echo; write only while idle.
// Path: an accepted item goes into the input register; when it advances, its
//   result, if it gives one, is loaded into the result register, from which
//   it is offered.
// Throughput: one item per cycle unless stalled; the frame state update (8-bit
//   sum, count, header compares) is one short stage between the two registers.
// Stall: while a waiting result is not taken, the result register holds, the
//   input register still takes one more item if empty, then in_tready drops
//   until the result is taken.
// Reset: rst_n low clears both valid flags, the frame state (empty frame,
//   header good) and the expected command to zero.
`include "reply_frame_checker_top_macros.svh"

module reply_frame_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,    // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                   // [17:10] payload_length, [23:18] zero
  output logic        out_tuser,   // is_status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data     // expected_command
);

  logic             in_valid_r;
  rfc_pkg::item_t   item_r;
  logic [7:0]       exp_cmd_r;
  logic             fire;
  logic             adv_ok;
  rfc_pkg::result_t res;
  rfc_pkg::result_t out_res;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_r && adv_ok;
  assign in_tready = !in_valid_r || adv_ok;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      exp_cmd_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.rx_byte   <= in_tdata;
      item_r.frame_end <= in_tlast;
    end
  end

  rfc_frame_eval u_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .item             (item_r),
    .expected_command (exp_cmd_r),
    .res              (res)
  );

  rfc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .adv_ok     (adv_ok),
    .out_res    (out_res)
  );

  // result packing
  assign out_tuser = out_res.is_status;
  assign out_tdata = {6'd0, out_res.payload_length, out_res.frame_status,
                      out_res.payload_byte};

  `RFC_ASSERT_NXT(a_hold_input, in_valid_r && !fire, in_valid_r, "input item lost")
  `RFC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid,
                  "result item dropped while stalled")
  `RFC_ASSERT_IMP(a_len_only_ok,
                  out_tvalid && (!out_tuser || out_res.frame_status != rfc_pkg::ST_OK),
                  out_res.payload_length == 8'd0, "length on non-ok item")

endmodule
